[rtl/core/mne_pkg.sv]
// Shared types, widths and MIDI byte constants for the note event encoder.
package mne_pkg;

  localparam int NoteW    = 7;
  localparam int VelW     = 7;
  localparam int TickW    = 28;
  localparam int VoiceW   = 2;
  localparam int InstW    = 7;
  localparam int ChanW    = 4;
  localparam int ByteW    = 8;
  localparam int GroupW   = 7;
  localparam int GrpCntW  = 2;

  localparam int QueueDepthDef = 2;

  localparam logic [ByteW-1:0]  ProgChangeStatus = 8'hC0;
  localparam logic [ByteW-1:0]  NoteOnStatus     = 8'h90;
  localparam logic [ByteW-1:0]  ZeroByte         = 8'h00;
  localparam logic [ByteW-1:0]  VlqContinue      = 8'h80;
  localparam logic [VoiceW-1:0] PercVoice        = 2'd3;
  localparam logic [ChanW-1:0]  PercChannel      = 4'd9;

  // Classified note request, as held in the queue between front and back.
  typedef struct packed {
    logic [NoteW-1:0]   note;
    logic [VelW-1:0]    vel;
    logic [TickW-1:0]   len;
    logic [TickW-1:0]   dly;
    logic               first;
    logic [ChanW-1:0]   chan;
    logic [InstW-1:0]   inst;
    logic [GrpCntW-1:0] dly_top;   // index of the most significant VLQ group
    logic [GrpCntW-1:0] len_top;
  } cmd_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

  typedef enum logic [3:0] {
    PH_DLY,
    PH_PROG,
    PH_INST,
    PH_DZERO,
    PH_STATUS,
    PH_NOTE,
    PH_VEL,
    PH_LEN,
    PH_OFF_NOTE,
    PH_OFF_VEL
  } phase_e;

  // Index of the highest nonzero 7-bit group; zero gives group 0.
  function automatic logic [GrpCntW-1:0] vlq_top(input logic [TickW-1:0] v);
    logic [GrpCntW-1:0] r;
    if (v[TickW-1:3*GroupW] != '0) begin
      r = 2'd3;
    end else if (v[3*GroupW-1:2*GroupW] != '0) begin
      r = 2'd2;
    end else if (v[2*GroupW-1:GroupW] != '0) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

[rtl/core/mne_req_if.sv]
// Channel interface that carries one note request per item.
interface mne_req_if;
  logic                          valid;
  logic                          ready;
  logic [mne_pkg::NoteW-1:0]     note_number;
  logic [mne_pkg::VelW-1:0]      velocity;
  logic [mne_pkg::TickW-1:0]     note_length;
  logic [mne_pkg::TickW-1:0]     delay_before;
  logic                          first_note;
  logic [mne_pkg::VoiceW-1:0]    voice;
  logic [mne_pkg::InstW-1:0]     instrument;

  modport source (
    output valid, note_number, velocity, note_length, delay_before, first_note, voice,
           instrument,
    input  ready
  );
  modport sink (
    input  valid, note_number, velocity, note_length, delay_before, first_note, voice,
           instrument,
    output ready
  );
endinterface

[rtl/core/mne_byte_if.sv]
// Channel interface that carries one MIDI track byte per item.
interface mne_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mne_pkg::ByteW-1:0]  out_byte;
  logic                       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

[rtl/core/mne_front.sv]
// Front end: accepts note requests and classifies them into queue commands.
module mne_front (
  mne_req_if.sink        req_i,
  input  logic           q_full_i,
  output logic           push_o,
  output mne_pkg::cmd_t  cmd_o
);
  import mne_pkg::*;

  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && !q_full_i;

  always_comb begin
    cmd_o.note    = req_i.note_number;
    cmd_o.vel     = req_i.velocity;
    cmd_o.len     = req_i.note_length;
    cmd_o.dly     = req_i.delay_before;
    cmd_o.first   = req_i.first_note;
    cmd_o.chan    = (req_i.voice == PercVoice) ? PercChannel
                                               : ChanW'(req_i.voice);
    cmd_o.inst    = req_i.instrument;
    cmd_o.dly_top = vlq_top(req_i.delay_before);
    cmd_o.len_top = vlq_top(req_i.note_length);
  end

endmodule

[rtl/core/mne_queue.sv]
// Small command queue between the front end and the byte sequencer.
module mne_queue #(
  parameter int Depth = mne_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mne_pkg::cmd_t   cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mne_pkg::cmd_t   head_o
);
  import mne_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[rtl/core/mne_back.sv]
// Back end: walks the queue head through its byte sequence into the output register.
module mne_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mne_pkg::cmd_t    head_i,
  input  mne_pkg::q_ctl_t  q_ctl_i,
  output logic             pop_o,
  mne_byte_if.source       byte_o
);
  import mne_pkg::*;

  phase_e             phase_q, phase_d;
  logic [GrpCntW-1:0] grp_q, grp_d;
  logic               out_valid_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               out_last_q;

  logic               advance;
  logic [ByteW-1:0]   byte_value;
  logic               byte_last;
  logic [TickW-1:0]   vlq_value;
  logic [GrpCntW-1:0] vlq_top_idx;
  logic [GrpCntW-1:0] vlq_idx;
  logic [GroupW-1:0]  vlq_group;

  assign advance = q_ctl_i.valid && (!out_valid_q || byte_o.ready);
  assign pop_o   = advance && byte_last;

  // The VLQ phases count groups up from zero; the group index runs down.
  assign vlq_value   = (phase_q == PH_LEN) ? head_i.len : head_i.dly;
  assign vlq_top_idx = (phase_q == PH_LEN) ? head_i.len_top : head_i.dly_top;
  assign vlq_idx     = vlq_top_idx - grp_q;

  always_comb begin
    case (vlq_idx)
      2'd0:    vlq_group = vlq_value[GroupW-1:0];
      2'd1:    vlq_group = vlq_value[2*GroupW-1:GroupW];
      2'd2:    vlq_group = vlq_value[3*GroupW-1:2*GroupW];
      default: vlq_group = vlq_value[4*GroupW-1:3*GroupW];
    endcase
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    grp_d   = grp_q;
    if (advance) begin
      unique case (phase_q)
        PH_DLY: begin
          if (grp_q == head_i.dly_top) begin
            grp_d   = '0;
            phase_d = head_i.first ? PH_PROG : PH_NOTE;
          end else begin
            grp_d = grp_q + 1'b1;
          end
        end
        PH_PROG:     phase_d = PH_INST;
        PH_INST:     phase_d = PH_DZERO;
        PH_DZERO:    phase_d = PH_STATUS;
        PH_STATUS:   phase_d = PH_NOTE;
        PH_NOTE:     phase_d = PH_VEL;
        PH_VEL:      phase_d = PH_LEN;
        PH_LEN: begin
          if (grp_q == head_i.len_top) begin
            grp_d   = '0;
            phase_d = PH_OFF_NOTE;
          end else begin
            grp_d = grp_q + 1'b1;
          end
        end
        PH_OFF_NOTE: phase_d = PH_OFF_VEL;
        PH_OFF_VEL:  phase_d = PH_DLY;
        default:     phase_d = PH_DLY;
      endcase
    end
  end

  // Byte for the current phase.
  always_comb begin
    byte_last = 1'b0;
    unique case (phase_q)
      PH_DLY, PH_LEN: begin
        byte_value = {(vlq_idx != '0), vlq_group};
      end
      PH_PROG:     byte_value = ProgChangeStatus | ByteW'(head_i.chan);
      PH_INST:     byte_value = ByteW'(head_i.inst);
      PH_DZERO:    byte_value = ZeroByte;
      PH_STATUS:   byte_value = NoteOnStatus | ByteW'(head_i.chan);
      PH_NOTE:     byte_value = ByteW'(head_i.note);
      PH_VEL:      byte_value = ByteW'(head_i.vel);
      PH_OFF_NOTE: byte_value = ByteW'(head_i.note);
      PH_OFF_VEL: begin
        byte_value = ZeroByte;
        byte_last  = 1'b1;
      end
      default:     byte_value = ZeroByte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DLY;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      grp_q   <= grp_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_value;
      out_last_q <= byte_last;
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.out_byte  = out_byte_q;
  assign byte_o.last_byte = out_last_q;

endmodule

[rtl/core/midi_note_event_encoder_unit.sv]
// Top level of the MIDI note event encoder: front end, command queue and byte sequencer.
//
// Usage: a note request (note number, velocity, length, delay, first-note flag, voice,
// instrument) is one item on req_i. The block answers with 6 to 16 MIDI track bytes on
// byte_o, one item per byte, in stream order: the delay as a variable-length quantity,
// the program change group on a first note, note-on note and velocity, the length as a
// variable-length quantity, and the running-status note-off. last_byte marks the final
// byte of each request.
// Path: an accepted request is written into the command queue, and its first byte is then
// loaded from the queue head into the output byte register when the sequencer is free.
// Throughput: one byte per cycle while requests are queued and byte_o.ready stays high;
// the single output byte register sets this rate. The command queue of QueueDepth entries
// lets the front end take further requests while bytes of an earlier one are still going out.
// Reset clears the queue and the sequencer; no output byte is valid afterward.
// When the receiver holds byte_o.ready low, the current byte stays in the output
// register and the sequencer waits; once the queue is full, req_i.ready drops.
module midi_note_event_encoder_unit #(
  parameter int QueueDepth = mne_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mne_req_if.sink     req_i,
  mne_byte_if.source  byte_o
);
  import mne_pkg::*;

  logic   push;
  logic   q_full;
  cmd_t   push_cmd;
  cmd_t   head_cmd;
  q_ctl_t q_ctl;
  logic   q_valid;
  logic   q_pop;

  // Classification of incoming requests.
  mne_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Decouples request intake from byte emission.
  mne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head_cmd)
  );

  assign q_ctl.valid = q_valid;
  assign q_ctl.pop   = q_pop;

  // Byte sequencer; it pops the head entry together with its final byte.
  mne_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_cmd),
    .q_ctl_i (q_ctl),
    .pop_o   (q_pop),
    .byte_o  (byte_o)
  );

  // The sequencer only pops an entry that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_ctl.pop |-> q_ctl.valid)
    else $error("queue popped while empty");

  // A pop always loads the final byte of its request into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_pop |=> (byte_o.valid && byte_o.last_byte))
    else $error("pop without a final byte");

  // A request taken into an empty queue is visible to the sequencer next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push && !q_valid) |=> q_valid)
    else $error("accepted request lost");

  // The front end only refuses requests when the queue holds work.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !req_i.ready |-> q_valid)
    else $error("request refused with an empty queue");

endmodule

[tb/midi_note_event_encoder_unit_tb.sv]
// Self-checking testbench for the MIDI note event encoder: directed and random requests.
`timescale 1ns / 1ps

module midi_note_event_encoder_unit_tb;
  import mne_pkg::*;

  localparam int  HalfPeriod  = 10;
  localparam int  ResetCycles = 11;
  localparam int  CycleLimit  = 200000;
  localparam int  TailCycles  = 40;
  localparam int  ItemsPerMix = 85;
  localparam logic [TickW-1:0] TickMax = '1;

  // One note request as it travels on req_i.
  typedef struct packed {
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic [TickW-1:0]  len;
    logic [TickW-1:0]  dly;
    logic              first;
    logic [VoiceW-1:0] voice;
    logic [InstW-1:0]  inst;
  } note_req_t;

  // One track byte that the encoder is expected to emit.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } track_byte_t;

  logic clk_i;
  logic rst_ni;

  mne_req_if  req_if ();
  mne_byte_if byte_if ();

  midi_note_event_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .byte_o (byte_if)
  );

  track_byte_t pending_bytes[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;

  initial begin
    clk_i = 1'b0;
  end

  always #HalfPeriod clk_i = ~clk_i;

  // Appends a tick count as a variable-length quantity, most significant group first.
  function automatic void push_vlq(ref logic [ByteW-1:0] stream[$],
                                   input logic [TickW-1:0] ticks);
    int groups;
    groups = 1;
    while (groups < 4 && (ticks >> (GroupW * groups)) != '0) groups++;
    for (int k = groups - 1; k >= 0; k--) begin
      stream.push_back({(k != 0), ticks[GroupW*k +: GroupW]});
    end
  endfunction

  // Works out the byte stream for one accepted request and queues it for checking.
  function automatic void predict_track_bytes(input note_req_t r);
    logic [ByteW-1:0] stream[$];
    logic [ChanW-1:0] chan;
    chan = (r.voice == PercVoice) ? PercChannel : ChanW'(r.voice);
    push_vlq(stream, r.dly);
    if (r.first) begin
      stream.push_back(ProgChangeStatus | ByteW'(chan));
      stream.push_back(ByteW'(r.inst));
      stream.push_back(ZeroByte);
      stream.push_back(NoteOnStatus | ByteW'(chan));
    end
    stream.push_back(ByteW'(r.note));
    stream.push_back(ByteW'(r.vel));
    push_vlq(stream, r.len);
    stream.push_back(ByteW'(r.note));
    stream.push_back(ZeroByte);
    foreach (stream[i]) begin
      pending_bytes.push_back('{data: stream[i], last: (i == stream.size() - 1)});
    end
  endfunction

  function automatic note_req_t make_request(input int note, input int vel,
                                             input logic [TickW-1:0] len,
                                             input logic [TickW-1:0] dly,
                                             input bit first, input int voice,
                                             input int inst);
    note_req_t r;
    r.note  = NoteW'(note);
    r.vel   = VelW'(vel);
    r.len   = len;
    r.dly   = dly;
    r.first = first;
    r.voice = VoiceW'(voice);
    r.inst  = InstW'(inst);
    return r;
  endfunction

  // Tick counts spread over every VLQ length, plus fully random bit patterns.
  function automatic logic [TickW-1:0] random_ticks();
    logic [TickW-1:0] t;
    case ($urandom_range(0, 5))
      0: t = '0;
      1: t = TickW'($urandom_range(1, 127));
      2: t = TickW'($urandom_range(128, 16383));
      3: t = TickW'($urandom_range(16384, 2097151));
      4: t = TickW'($urandom_range(2097152, 268435455));
      default: t = TickW'($urandom());
    endcase
    return t;
  endfunction

  function automatic note_req_t random_request();
    return make_request($urandom_range(0, 127), $urandom_range(0, 127), random_ticks(),
                        random_ticks(), ($urandom_range(0, 2) == 0),
                        $urandom_range(0, 3), $urandom_range(0, 127));
  endfunction

  // Offers one request, called at a falling edge. Valid stays high after the item is
  // taken so that back-to-back items never lower and raise it in one time step.
  task automatic send_request(input note_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      note_req_t noise;
      noise = random_request();
      req_if.valid        <= 1'b0;
      req_if.note_number  <= noise.note;
      req_if.delay_before <= noise.dly;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.note_number  <= r.note;
    req_if.velocity     <= r.vel;
    req_if.note_length  <= r.len;
    req_if.delay_before <= r.dly;
    req_if.first_note   <= r.first;
    req_if.voice        <= r.voice;
    req_if.instrument   <= r.inst;
    do @(posedge clk_i); while (!req_if.ready);
    predict_track_bytes(r);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted byte has been seen.
  task automatic wait_all_bytes();
    req_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_vlq_boundaries();
    send_request(make_request(0, 0, '0, '0, 1'b0, 0, 0));
    send_request(make_request(127, 127, TickMax, TickMax, 1'b1, 3, 127));
    send_request(make_request(60, 100, 28'd128, 28'd127, 1'b0, 1, 5));
    send_request(make_request(61, 101, 28'd127, 28'd128, 1'b0, 2, 6));
    send_request(make_request(62, 1, 28'd16384, 28'd16383, 1'b1, 0, 7));
    send_request(make_request(63, 2, 28'd16383, 28'd16384, 1'b0, 1, 8));
    send_request(make_request(64, 3, 28'd2097152, 28'd2097151, 1'b0, 2, 9));
    send_request(make_request(65, 4, 28'd2097151, 28'd2097152, 1'b1, 3, 10));
    send_request(make_request(85, 42, 28'hAAAAAAA, 28'h5555555, 1'b0, 0, 0));
    send_request(make_request(42, 85, 28'h5555555, 28'hAAAAAAA, 1'b1, 1, 85));
  endtask

  // Program change group on every voice, including the percussion channel, and a
  // percussion note that relies on running status.
  task automatic test_voices_and_programs();
    send_request(make_request(36, 64, 28'd96, 28'd0, 1'b1, 0, 0));
    send_request(make_request(38, 90, 28'd0, 28'd24, 1'b1, 1, 1));
    send_request(make_request(40, 127, 28'd480, 28'd480, 1'b1, 2, 64));
    send_request(make_request(42, 0, 28'd1, 28'd1, 1'b1, 3, 127));
    send_request(make_request(44, 77, 28'd300, 28'd0, 1'b0, 3, 33));
    send_request(make_request(127, 0, 28'd0, 28'd0, 1'b1, 2, 0));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_request());
  endtask

  // The receiver refuses bytes for a long stretch while requests keep coming, so the
  // command queue fills and req_i.ready must drop; then the sender waits for a drain.
  task automatic test_output_hold_off();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 300;
    repeat (12) send_request(random_request());
    wait_all_bytes();
    repeat (6) send_request(random_request());
    wait_all_bytes();
  endtask

  // Receiver side: random stalls, or a counted hold-off when a test asks for one.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      byte_if.ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      byte_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every accepted byte is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, byte_if.out_byte,
                 byte_if.last_byte);
        error_count++;
      end else begin
        track_byte_t want;
        want = pending_bytes.pop_front();
        if (byte_if.out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data,
                   byte_if.out_byte);
          error_count++;
        end
        if (byte_if.last_byte !== want.last) begin
          $display("%0t: last_byte expected %b actual %b", $time, want.last,
                   byte_if.last_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.note_number  = '0;
    req_if.velocity     = '0;
    req_if.note_length  = '0;
    req_if.delay_before = '0;
    req_if.first_note   = 1'b0;
    req_if.voice        = '0;
    req_if.instrument   = '0;
    byte_if.ready       = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_vlq_boundaries();
    test_voices_and_programs();
    test_random_traffic(ItemsPerMix, 0, 0);
    test_random_traffic(ItemsPerMix, 82, 0);
    test_output_hold_off();
    test_random_traffic(ItemsPerMix, 0, 82);
    test_random_traffic(ItemsPerMix, 14, 14);
    test_random_traffic(20, 0, 0);

    wait_all_bytes();
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
